// ===== sv/vpbu_pkg.sv =====
// Shared constants and types of the voxel pattern bit unpacker.
package vpbu_pkg;

    localparam int MAX_SIDE    = 16;
    localparam int SIDE_W      = 5;
    localparam int COORD_W     = 4;
    localparam int COUNT_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = $clog2(BYTE_W);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int SIDE_RESET  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIDE    = 1'b0,
        REG_PATTERN_COUNT = 1'b1
    } cfg_reg_t;

    // Configuration as the back end uses it: last coordinate and pattern limit.
    typedef struct packed {
        logic [COORD_W-1:0] last;
        logic [COUNT_W-1:0] count;
    } eff_cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

// ===== sv/vpbu_front.sv =====
// Front end: configuration registers, side clamping and input byte acceptance.
module vpbu_front
    import vpbu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  fifo_status_t          fifo_status,
    output logic                  push,
    output logic [BYTE_W-1:0]     push_data,
    output eff_cfg_t              eff_cfg
);

    logic [SIDE_W-1:0]  block_side_reg;
    logic [SIDE_W-1:0]  block_side_next;
    logic [COUNT_W-1:0] pattern_count_reg;
    logic [COUNT_W-1:0] pattern_count_next;
    logic [SIDE_W-1:0]  side_eff;
    logic [SIDE_W-1:0]  side_minus_one;

    always_comb
    begin
        block_side_next    = block_side_reg;
        pattern_count_next = pattern_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLOCK_SIDE:    block_side_next    = cfg_data[SIDE_W-1:0];
                REG_PATTERN_COUNT: pattern_count_next = cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_side_reg    <= SIDE_W'(SIDE_RESET);
            pattern_count_reg <= '0;
        end
        else
        begin
            block_side_reg    <= block_side_next;
            pattern_count_reg <= pattern_count_next;
        end
    end

    // A side of zero acts as one, and anything above the maximum is clamped.
    always_comb
    begin
        priority if (block_side_reg == '0)
            side_eff = SIDE_W'(1);
        else if (block_side_reg > SIDE_W'(MAX_SIDE))
            side_eff = SIDE_W'(MAX_SIDE);
        else
            side_eff = block_side_reg;
        side_minus_one = side_eff - SIDE_W'(1);
    end

    assign eff_cfg.last  = side_minus_one[COORD_W-1:0];
    assign eff_cfg.count = pattern_count_reg;

    assign in_stall  = fifo_status.full;
    assign push      = in_valid && !fifo_status.full;
    assign push_data = data_byte;

endmodule

// ===== sv/vpbu_fifo.sv =====
// Small byte queue between the front end and the unpacking back end.
module vpbu_fifo
    import vpbu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BYTE_W-1:0] push_data,
    input  logic              pop,
    output logic [BYTE_W-1:0] head_data,
    output fifo_status_t      status
);

    logic [BYTE_W-1:0]  entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg;
    logic [FIFO_AW:0]   fill_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = entry_reg[rd_ptr_reg];
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == (FIFO_AW+1)'(FIFO_DEPTH));

endmodule

// ===== sv/vpbu_back.sv =====
// Back end: walks the head byte's bits; one voxel per cycle unless starved or stalled.
module vpbu_back
    import vpbu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  eff_cfg_t           eff_cfg,
    input  fifo_status_t       fifo_status,
    input  logic [BYTE_W-1:0]  head_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] pattern_index,
    output logic [COORD_W-1:0] voxel_x,
    output logic [COORD_W-1:0] voxel_y,
    output logic [COORD_W-1:0] voxel_z,
    output logic               occupied,
    output logic               pattern_end,
    output logic               run_last
);

    logic [COUNT_W-1:0]   pattern_counter_reg;
    logic [COUNT_W-1:0]   pattern_counter_next;
    logic [COORD_W-1:0]   x_counter_reg;
    logic [COORD_W-1:0]   x_counter_next;
    logic [COORD_W-1:0]   y_counter_reg;
    logic [COORD_W-1:0]   y_counter_next;
    logic [COORD_W-1:0]   z_counter_reg;
    logic [COORD_W-1:0]   z_counter_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg;
    logic [BIT_IDX_W-1:0] bit_idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [COUNT_W-1:0]   pattern_index_reg;
    logic [COORD_W-1:0]   voxel_x_reg;
    logic [COORD_W-1:0]   voxel_y_reg;
    logic [COORD_W-1:0]   voxel_z_reg;
    logic                 occupied_reg;
    logic                 pattern_end_reg;
    logic                 run_last_reg;

    logic advance;
    logic stream_done;
    logic emit;
    logic x_wrap;
    logic y_wrap;
    logic z_wrap;
    logic end_of_pattern;
    logic last_bit;

    assign advance        = !fifo_status.empty && (!out_valid_reg || !out_stall);
    assign stream_done    = (pattern_counter_reg >= eff_cfg.count);
    assign emit           = advance && !stream_done;
    assign x_wrap         = (x_counter_reg >= eff_cfg.last);
    assign y_wrap         = (y_counter_reg >= eff_cfg.last);
    assign z_wrap         = (z_counter_reg >= eff_cfg.last);
    assign end_of_pattern = x_wrap && y_wrap && z_wrap;
    assign last_bit       = (bit_idx_reg == BIT_IDX_W'(BYTE_W-1));

    // Once every pattern is complete the head byte is dropped without emitting a voxel.
    // Otherwise it is popped after its eighth bit or after a pattern's final
    // voxel, which discards the padding bits.
    assign pop = advance && (stream_done || last_bit || end_of_pattern);

    always_comb
    begin
        pattern_counter_next = pattern_counter_reg;
        x_counter_next       = x_counter_reg;
        y_counter_next       = y_counter_reg;
        z_counter_next       = z_counter_reg;
        bit_idx_next         = bit_idx_reg;
        if (emit)
        begin
            if (x_wrap)
            begin
                x_counter_next = '0;
                if (y_wrap)
                begin
                    y_counter_next = '0;
                    if (z_wrap)
                        z_counter_next = '0;
                    else
                        z_counter_next = z_counter_reg + COORD_W'(1);
                end
                else
                begin
                    y_counter_next = y_counter_reg + COORD_W'(1);
                end
            end
            else
            begin
                x_counter_next = x_counter_reg + COORD_W'(1);
            end
            if (end_of_pattern)
                pattern_counter_next = pattern_counter_reg + COUNT_W'(1);
        end
        if (pop)
            bit_idx_next = '0;
        else if (emit)
            bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
        if (emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_stall)
            out_valid_next = 1'b1;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_counter_reg <= '0;
            x_counter_reg       <= '0;
            y_counter_reg       <= '0;
            z_counter_reg       <= '0;
            bit_idx_reg         <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            pattern_counter_reg <= pattern_counter_next;
            x_counter_reg       <= x_counter_next;
            y_counter_reg       <= y_counter_next;
            z_counter_reg       <= z_counter_next;
            bit_idx_reg         <= bit_idx_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pattern_index_reg <= pattern_counter_reg;
            voxel_x_reg       <= x_counter_reg;
            voxel_y_reg       <= y_counter_reg;
            voxel_z_reg       <= z_counter_reg;
            occupied_reg      <= head_data[bit_idx_reg];
            pattern_end_reg   <= end_of_pattern;
            run_last_reg      <= last_bit || end_of_pattern;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pattern_index = pattern_index_reg;
    assign voxel_x       = voxel_x_reg;
    assign voxel_y       = voxel_y_reg;
    assign voxel_z       = voxel_z_reg;
    assign occupied      = occupied_reg;
    assign pattern_end   = pattern_end_reg;
    assign run_last      = run_last_reg;

endmodule

// ===== sv/voxel_pattern_bit_unpacker_core.sv =====
// Top level of the voxel pattern bit unpacker: front end, byte queue and back end.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  input    | in        | in_valid/in_stall  | data_byte
//  output   | out       | out_valid/out_stall| pattern_index, voxel_x/y/z, occupied,
//           |           |                    | pattern_end, run_last
//  config   | in        | cfg_we             | cfg_index, cfg_data
//
// A byte yields one voxel per bit, up to eight; the back end takes bits from the head
// of a four-entry byte queue and, unless it is empty or the output stalls, produces
// one voxel per cycle. A byte that arrives after the last pattern leaves the queue unused.
// Results are registered and appear in the cycle after the back end takes the bit from the queue.
// Reset clears the counters and the queue; block_side resets to 8, pattern_count to 0.
// A stalled output holds the back end, and the input stalls only when the queue is full.
module voxel_pattern_bit_unpacker_core
    import vpbu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COUNT_W-1:0]    pattern_index,
    output logic [COORD_W-1:0]    voxel_x,
    output logic [COORD_W-1:0]    voxel_y,
    output logic [COORD_W-1:0]    voxel_z,
    output logic                  occupied,
    output logic                  pattern_end,
    output logic                  run_last
);

    eff_cfg_t          eff_cfg;
    fifo_status_t      fifo_status;
    logic              push;
    logic [BYTE_W-1:0] push_data;
    logic              pop;
    logic [BYTE_W-1:0] head_data;

    vpbu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .fifo_status (fifo_status),
        .push        (push),
        .push_data   (push_data),
        .eff_cfg     (eff_cfg)
    );

    vpbu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (fifo_status)
    );

    vpbu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .eff_cfg       (eff_cfg),
        .fifo_status   (fifo_status),
        .head_data     (head_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pattern_index (pattern_index),
        .voxel_x       (voxel_x),
        .voxel_y       (voxel_y),
        .voxel_z       (voxel_z),
        .occupied      (occupied),
        .pattern_end   (pattern_end),
        .run_last      (run_last)
    );

endmodule
